@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Check that a condition implies another in the following cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/rcp_pkg.sv @@
// ----------------------------------------------------------------------------
// rcp_pkg
// Types, event codes and character constants of the request command parser.
// ----------------------------------------------------------------------------
package rcp_pkg;

    // Width of the count, length and argument counters
    localparam int COUNT_BITS = 31;
    // Width of the argument index and count ports
    localparam int IDX_W      = 31;

    typedef logic [COUNT_BITS-1:0] cnt_t;
    typedef logic [COUNT_BITS+3:0] wide_t;
    typedef logic [IDX_W-1:0]      idx_t;

    localparam cnt_t NUM_MAX = '1;

    // Result event codes
    typedef enum logic [2:0] {
        EV_BYTE        = 3'd0,
        EV_ARG_END     = 3'd1,
        EV_CMD_END     = 3'd2,
        EV_ARG_CMD_END = 3'd3,
        EV_ERROR       = 3'd4,
        EV_EMPTY       = 3'd5,
        EV_BAD_START   = 3'd6
    } event_t;

    // Stream characters
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_TILDE  = 8'h7E;

endpackage

@@ rtl/resp_command_parser_top.sv @@
// ----------------------------------------------------------------------------
// resp_command_parser_top: byte-serial request command parser
// Each accepted item is held in the input register; its result is then registered in the result register.
// Throughput: 1 item per cycle while out_stall does not hold the result; the per-byte state update is a single pass.
// Reset: asynchronous, active low; parser returns to idle, pipeline empties.
// ----------------------------------------------------------------------------
module resp_command_parser_top (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [7:0]              stream_byte,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [2:0]              event_res,
    output logic [7:0]              data,
    output logic [rcp_pkg::IDX_W-1:0] arg_index,
    output logic [rcp_pkg::IDX_W-1:0] arg_count
);

    typedef enum logic [2:0] {
        M_IDLE    = 3'd0,
        M_COUNT   = 3'd1,
        M_DOLLAR  = 3'd2,
        M_LEN     = 3'd3,
        M_PAYLOAD = 3'd4,
        M_TERM    = 3'd5,
        M_INLINE  = 3'd6
    } mode_t;

    // Input register
    logic            in_valid_reg;
    logic [7:0]      byte_reg;

    // Parser state
    mode_t           mode_reg, mode_next;
    logic            cr_reg, cr_next;
    rcp_pkg::cnt_t   value_reg, value_next;
    logic            neg_reg, neg_next;
    logic            seen_reg, seen_next;
    logic            inv_reg, inv_next;
    rcp_pkg::cnt_t   args_reg, args_next;
    rcp_pkg::cnt_t   cur_reg, cur_next;
    rcp_pkg::cnt_t   pay_reg, pay_next;
    logic            tgood_reg, tgood_next;
    logic            tok_reg, tok_next;

    // Result register
    logic            out_valid_reg;
    rcp_pkg::event_t event_reg;
    logic [7:0]      data_reg;
    rcp_pkg::idx_t   idx_reg;
    rcp_pkg::idx_t   cnt_reg;

    // Result of the current pass
    logic            ev_valid;
    rcp_pkg::event_t ev_code;
    logic [7:0]      ev_data;
    rcp_pkg::cnt_t   ev_idx;
    rcp_pkg::cnt_t   ev_cnt;

    // Helpers
    logic            advance;
    logic            is_digit, is_space, is_print;
    rcp_pkg::wide_t  num_sum;
    logic            num_ovf;
    logic            header_bad;
    logic            inv_cur;
    logic            do_inline;
    logic            il_cr, il_tok;
    rcp_pkg::cnt_t   il_cur;

    // Move the item on when the result slot is free or being taken
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    // Classify the byte
    assign is_digit = (byte_reg >= rcp_pkg::CH_ZERO) && (byte_reg <= rcp_pkg::CH_NINE);
    assign is_space = (byte_reg == rcp_pkg::CH_SPACE) ||
                      ((byte_reg >= rcp_pkg::CH_TAB) && (byte_reg <= rcp_pkg::CH_CR));
    assign is_print = (byte_reg >= rcp_pkg::CH_SPACE) && (byte_reg <= rcp_pkg::CH_TILDE);

    // Accumulate one decimal digit with overflow check
    assign num_sum = (rcp_pkg::wide_t'(value_reg) << 3) + (rcp_pkg::wide_t'(value_reg) << 1)
                   + rcp_pkg::wide_t'(byte_reg[3:0]);
    assign num_ovf = num_sum > rcp_pkg::wide_t'(rcp_pkg::NUM_MAX);

    assign header_bad = inv_reg || !seen_reg || (neg_reg && (value_reg != '0));
    assign inv_cur    = inv_reg || cr_reg;

    // Next state and result for the item in the input register
    always_comb
    begin
        mode_next  = mode_reg;
        cr_next    = cr_reg;
        value_next = value_reg;
        neg_next   = neg_reg;
        seen_next  = seen_reg;
        inv_next   = inv_reg;
        args_next  = args_reg;
        cur_next   = cur_reg;
        pay_next   = pay_reg;
        tgood_next = tgood_reg;
        tok_next   = tok_reg;
        ev_valid   = 1'b0;
        ev_code    = rcp_pkg::EV_BYTE;
        ev_data    = 8'h00;
        ev_idx     = '0;
        ev_cnt     = '0;
        do_inline  = 1'b0;
        il_cr      = cr_reg;
        il_cur     = cur_reg;
        il_tok     = tok_reg;

        unique case (mode_reg)
            M_IDLE:
            begin
                if (byte_reg == rcp_pkg::CH_STAR)
                begin
                    cr_next    = 1'b0;
                    value_next = '0;
                    neg_next   = 1'b0;
                    seen_next  = 1'b0;
                    inv_next   = 1'b0;
                    mode_next  = M_COUNT;
                end
                else if (is_print)
                begin
                    mode_next = M_INLINE;
                    do_inline = 1'b1;
                    il_cr     = 1'b0;
                    il_cur    = '0;
                    il_tok    = 1'b0;
                end
                else
                begin
                    ev_valid = 1'b1;
                    ev_code  = rcp_pkg::EV_BAD_START;
                end
            end
            M_COUNT, M_LEN:
            begin
                if (cr_reg && (byte_reg == rcp_pkg::CH_LF))
                begin
                    cr_next = 1'b0;
                    if (header_bad)
                    begin
                        mode_next = M_IDLE;
                        ev_valid  = 1'b1;
                        ev_code   = rcp_pkg::EV_ERROR;
                    end
                    else if (mode_reg == M_COUNT)
                    begin
                        if (value_reg == '0)
                        begin
                            mode_next = M_IDLE;
                            ev_valid  = 1'b1;
                            ev_code   = rcp_pkg::EV_CMD_END;
                        end
                        else
                        begin
                            args_next = value_reg;
                            cur_next  = '0;
                            mode_next = M_DOLLAR;
                        end
                    end
                    else
                    begin
                        pay_next   = value_reg;
                        tgood_next = 1'b0;
                        mode_next  = (value_reg == '0) ? M_TERM : M_PAYLOAD;
                    end
                end
                else
                begin
                    // A CR not followed by LF spoils the number
                    inv_next = inv_cur;
                    if (byte_reg == rcp_pkg::CH_CR)
                    begin
                        cr_next = 1'b1;
                    end
                    else
                    begin
                        cr_next = 1'b0;
                        if (!inv_cur)
                        begin
                            if ((byte_reg == rcp_pkg::CH_MINUS) && !seen_reg && !neg_reg)
                            begin
                                neg_next = 1'b1;
                            end
                            else if (is_digit && !num_ovf)
                            begin
                                value_next = num_sum[rcp_pkg::COUNT_BITS-1:0];
                                seen_next  = 1'b1;
                            end
                            else
                            begin
                                inv_next = 1'b1;
                            end
                        end
                    end
                end
            end
            M_DOLLAR:
            begin
                if (byte_reg == rcp_pkg::CH_DOLLAR)
                begin
                    cr_next    = 1'b0;
                    value_next = '0;
                    neg_next   = 1'b0;
                    seen_next  = 1'b0;
                    inv_next   = 1'b0;
                    mode_next  = M_LEN;
                end
                else
                begin
                    mode_next = M_IDLE;
                    ev_valid  = 1'b1;
                    ev_code   = rcp_pkg::EV_ERROR;
                end
            end
            M_PAYLOAD:
            begin
                pay_next = pay_reg - rcp_pkg::cnt_t'(1);
                if (pay_reg == rcp_pkg::cnt_t'(1))
                begin
                    mode_next  = M_TERM;
                    cr_next    = 1'b0;
                    tgood_next = 1'b0;
                end
                ev_valid = 1'b1;
                ev_code  = rcp_pkg::EV_BYTE;
                ev_data  = byte_reg;
                ev_idx   = cur_reg;
            end
            M_TERM:
            begin
                if (!cr_reg)
                begin
                    tgood_next = (byte_reg == rcp_pkg::CH_CR);
                    cr_next    = 1'b1;
                end
                else
                begin
                    cr_next  = 1'b0;
                    ev_valid = 1'b1;
                    if (!(tgood_reg && (byte_reg == rcp_pkg::CH_LF)))
                    begin
                        mode_next = M_IDLE;
                        ev_code   = rcp_pkg::EV_ERROR;
                    end
                    else
                    begin
                        args_next = args_reg - rcp_pkg::cnt_t'(1);
                        ev_idx    = cur_reg;
                        if (args_reg == rcp_pkg::cnt_t'(1))
                        begin
                            mode_next = M_IDLE;
                            ev_code   = rcp_pkg::EV_ARG_CMD_END;
                            ev_cnt    = cur_reg + rcp_pkg::cnt_t'(1);
                        end
                        else
                        begin
                            mode_next = M_DOLLAR;
                            cur_next  = cur_reg + rcp_pkg::cnt_t'(1);
                            ev_code   = rcp_pkg::EV_ARG_END;
                        end
                    end
                end
            end
            M_INLINE:
            begin
                do_inline = 1'b1;
            end
            default:
            begin
                mode_next = M_IDLE;
            end
        endcase

        // Split an inline line into tokens
        if (do_inline)
        begin
            if (il_cr && (byte_reg == rcp_pkg::CH_LF))
            begin
                cr_next   = 1'b0;
                mode_next = M_IDLE;
                ev_valid  = 1'b1;
                if (il_cur != '0)
                begin
                    ev_code = rcp_pkg::EV_CMD_END;
                    ev_cnt  = il_cur;
                end
                else
                begin
                    ev_code = rcp_pkg::EV_EMPTY;
                end
            end
            else
            begin
                cr_next  = 1'b0;
                cur_next = il_cur;
                tok_next = il_tok;
                if (is_space)
                begin
                    if (byte_reg == rcp_pkg::CH_CR)
                    begin
                        cr_next = 1'b1;
                    end
                    if (il_tok)
                    begin
                        tok_next = 1'b0;
                        if (il_cur != rcp_pkg::NUM_MAX)
                        begin
                            cur_next = il_cur + rcp_pkg::cnt_t'(1);
                        end
                        ev_valid = 1'b1;
                        ev_code  = rcp_pkg::EV_ARG_END;
                        ev_idx   = il_cur;
                    end
                end
                else
                begin
                    tok_next = 1'b1;
                    ev_valid = 1'b1;
                    ev_code  = rcp_pkg::EV_BYTE;
                    ev_data  = byte_reg;
                    ev_idx   = il_cur;
                end
            end
        end
    end

    // Hold input item, parser state and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            byte_reg      <= 8'h00;
            mode_reg      <= M_IDLE;
            cr_reg        <= 1'b0;
            value_reg     <= '0;
            neg_reg       <= 1'b0;
            seen_reg      <= 1'b0;
            inv_reg       <= 1'b0;
            args_reg      <= '0;
            cur_reg       <= '0;
            pay_reg       <= '0;
            tgood_reg     <= 1'b0;
            tok_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            event_reg     <= rcp_pkg::EV_BYTE;
            data_reg      <= 8'h00;
            idx_reg       <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                in_valid_reg <= 1'b1;
                byte_reg     <= stream_byte;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                mode_reg      <= mode_next;
                cr_reg        <= cr_next;
                value_reg     <= value_next;
                neg_reg       <= neg_next;
                seen_reg      <= seen_next;
                inv_reg       <= inv_next;
                args_reg      <= args_next;
                cur_reg       <= cur_next;
                pay_reg       <= pay_next;
                tgood_reg     <= tgood_next;
                tok_reg       <= tok_next;
                out_valid_reg <= ev_valid;
                event_reg     <= ev_code;
                data_reg      <= ev_data;
                idx_reg       <= rcp_pkg::idx_t'(ev_idx);
                cnt_reg       <= rcp_pkg::idx_t'(ev_cnt);
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign event_res = event_reg;
    assign data      = data_reg;
    assign arg_index = idx_reg;
    assign arg_count = cnt_reg;

    // Checks
`include "assert_macros.svh"

    `ASSERT_SAME(a_data_only_on_byte, clk, rst_n,
        out_valid_reg && (event_reg != rcp_pkg::EV_BYTE), data_reg == 8'h00)
    `ASSERT_SAME(a_no_fields_on_error, clk, rst_n,
        out_valid_reg && ((event_reg == rcp_pkg::EV_ERROR) || (event_reg == rcp_pkg::EV_EMPTY)
        || (event_reg == rcp_pkg::EV_BAD_START)), (idx_reg == '0) && (cnt_reg == '0))
    `ASSERT_SAME(a_payload_nonzero, clk, rst_n,
        mode_reg == M_PAYLOAD, pay_reg != '0)
    `ASSERT_SAME(a_args_nonzero, clk, rst_n,
        (mode_reg == M_DOLLAR) || (mode_reg == M_TERM) || (mode_reg == M_LEN)
        || (mode_reg == M_PAYLOAD), args_reg != '0)
    `ASSERT_NEXT(a_held_item_kept, clk, rst_n,
        in_valid_reg && !advance, in_valid_reg && $stable(byte_reg))

endmodule

@@ dv/tb_resp_command_parser_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_resp_command_parser_top
// Self-checking bench for the request command parser. A queue of stream
// bytes (directed framing cases, then random array commands, inline lines
// and malformed traffic) feeds a valid/stall driver. Each accepted byte is
// run through a local parser model, and every result the block hands out
// is compared against the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_resp_command_parser_top;

    localparam int CYCLE_LIMIT = 100000;
    localparam int ITEM_TARGET = 1850;
    localparam int IDLE_PCT    = 27;
    localparam int HOLD_START  = 700;
    localparam int HOLD_LEN    = 300;
    localparam int QUIET_LO    = 1500;
    localparam int QUIET_HI    = 2100;
    localparam int DRAIN_WAIT  = 8;

    // Extra whitespace characters of the inline form
    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;

    // Defects planted in array commands
    localparam int FLAW_NONE   = 0;
    localparam int FLAW_HEADER = 1;
    localparam int FLAW_DOLLAR = 2;
    localparam int FLAW_TERM   = 3;

    typedef enum logic [2:0] {
        PM_IDLE,
        PM_COUNT,
        PM_DOLLAR,
        PM_LEN,
        PM_PAYLOAD,
        PM_TERM,
        PM_INLINE
    } parse_mode_t;

    typedef struct packed {
        logic [2:0]    ev;
        logic [7:0]    data;
        rcp_pkg::idx_t index;
        rcp_pkg::idx_t count;
    } parse_result_t;

    logic          clk         = 1'b0;
    logic          rst_n       = 1'b0;
    logic          in_valid    = 1'b0;
    logic [7:0]    stream_byte = 8'h00;
    logic          out_stall   = 1'b0;
    logic          in_stall;
    logic          out_valid;
    logic [2:0]    event_res;
    logic [7:0]    data;
    rcp_pkg::idx_t arg_index;
    rcp_pkg::idx_t arg_count;

    logic [7:0]    stream_q[$];
    parse_result_t expected_q[$];
    parse_result_t predicted;
    parse_result_t want;
    parse_result_t got;
    int            cycle_count    = 0;
    int            hold_left      = 0;
    int            mismatch_count = 0;

    // Parser model state
    parse_mode_t   pmode        = PM_IDLE;
    bit            cr_seen      = 1'b0;
    rcp_pkg::cnt_t num_val      = '0;
    bit            num_neg      = 1'b0;
    bit            num_digit    = 1'b0;
    bit            num_bad      = 1'b0;
    rcp_pkg::cnt_t args_left    = '0;
    rcp_pkg::cnt_t arg_no       = '0;
    rcp_pkg::cnt_t payload_left = '0;
    bit            term_ok      = 1'b0;
    bit            token_live   = 1'b0;

    resp_command_parser_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .stream_byte (stream_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_res   (event_res),
        .data        (data),
        .arg_index   (arg_index),
        .arg_count   (arg_count)
    );

    always #5 clk = ~clk;

    function automatic bit is_blank(input logic [7:0] b);
        return (b == rcp_pkg::CH_SPACE) || (b == rcp_pkg::CH_TAB) || (b == rcp_pkg::CH_LF) ||
               (b == CH_VT) || (b == CH_FF) || (b == rcp_pkg::CH_CR);
    endfunction

    function automatic bit in_quiet_stretch();
        return (cycle_count >= QUIET_LO) && (cycle_count < QUIET_HI);
    endfunction

    function automatic parse_result_t make_result(input rcp_pkg::event_t ev,
                                                  input logic [7:0] d,
                                                  input rcp_pkg::idx_t idx,
                                                  input rcp_pkg::idx_t cnt);
        parse_result_t r;
        r.ev    = ev;
        r.data  = d;
        r.index = idx;
        r.count = cnt;
        return r;
    endfunction

    function automatic string fmt_result(input parse_result_t r);
        return $sformatf("ev %0d data %02h idx %0d cnt %0d", r.ev, r.data, r.index, r.count);
    endfunction

    function automatic void clear_number();
        cr_seen   = 1'b0;
        num_val   = '0;
        num_neg   = 1'b0;
        num_digit = 1'b0;
        num_bad   = 1'b0;
    endfunction

    // One byte of an inline line: split tokens on blanks, close on CR LF
    function automatic bit inline_step(input logic [7:0] b, output parse_result_t res);
        rcp_pkg::cnt_t idx;
        res = '0;
        if (cr_seen)
        begin
            cr_seen = 1'b0;
            if (b == rcp_pkg::CH_LF)
            begin
                pmode = PM_IDLE;
                if (arg_no != '0)
                    res = make_result(rcp_pkg::EV_CMD_END, 8'h00, '0,
                                      rcp_pkg::idx_t'(arg_no));
                else
                    res = make_result(rcp_pkg::EV_EMPTY, 8'h00, '0, '0);
                return 1'b1;
            end
        end
        if (is_blank(b))
        begin
            if (b == rcp_pkg::CH_CR)
                cr_seen = 1'b1;
            if (token_live)
            begin
                idx        = arg_no;
                token_live = 1'b0;
                if (arg_no != rcp_pkg::NUM_MAX)
                    arg_no = arg_no + rcp_pkg::cnt_t'(1);
                res = make_result(rcp_pkg::EV_ARG_END, 8'h00, rcp_pkg::idx_t'(idx), '0);
                return 1'b1;
            end
            return 1'b0;
        end
        token_live = 1'b1;
        res = make_result(rcp_pkg::EV_BYTE, b, rcp_pkg::idx_t'(arg_no), '0);
        return 1'b1;
    endfunction

    // Advance the parser model by one byte; returns 1 when a result is due
    function automatic bit parse_byte(input logic [7:0] b, output parse_result_t res);
        logic [31:0] digit;
        logic [31:0] headroom;
        bit          bad;
        res = '0;
        case (pmode)
            PM_IDLE:
            begin
                if (b == rcp_pkg::CH_STAR)
                begin
                    clear_number();
                    pmode = PM_COUNT;
                    return 1'b0;
                end
                if (b >= rcp_pkg::CH_SPACE && b <= rcp_pkg::CH_TILDE)
                begin
                    pmode      = PM_INLINE;
                    cr_seen    = 1'b0;
                    arg_no     = '0;
                    token_live = 1'b0;
                    return inline_step(b, res);
                end
                res = make_result(rcp_pkg::EV_BAD_START, 8'h00, '0, '0);
                return 1'b1;
            end
            PM_COUNT, PM_LEN:
            begin
                if (cr_seen)
                begin
                    cr_seen = 1'b0;
                    if (b != rcp_pkg::CH_LF)
                    begin
                        num_bad = 1'b1;
                    end
                    else
                    begin
                        bad = num_bad || !num_digit || (num_neg && num_val != '0);
                        if (bad)
                        begin
                            pmode = PM_IDLE;
                            res = make_result(rcp_pkg::EV_ERROR, 8'h00, '0, '0);
                            return 1'b1;
                        end
                        if (pmode == PM_COUNT)
                        begin
                            if (num_val == '0)
                            begin
                                pmode = PM_IDLE;
                                res = make_result(rcp_pkg::EV_CMD_END, 8'h00, '0, '0);
                                return 1'b1;
                            end
                            args_left = num_val;
                            arg_no    = '0;
                            pmode     = PM_DOLLAR;
                        end
                        else
                        begin
                            payload_left = num_val;
                            term_ok      = 1'b0;
                            pmode        = (num_val == '0) ? PM_TERM : PM_PAYLOAD;
                        end
                        return 1'b0;
                    end
                end
                if (b == rcp_pkg::CH_CR)
                begin
                    cr_seen = 1'b1;
                end
                else if (!num_bad)
                begin
                    // accumulate the decimal value, refusing past the counter limit
                    if (b == rcp_pkg::CH_MINUS && !num_digit && !num_neg)
                    begin
                        num_neg = 1'b1;
                    end
                    else if (b >= rcp_pkg::CH_ZERO && b <= rcp_pkg::CH_NINE)
                    begin
                        digit    = 32'(b - rcp_pkg::CH_ZERO);
                        headroom = ({1'b0, rcp_pkg::NUM_MAX} - digit) / 32'd10;
                        if ({1'b0, num_val} > headroom)
                        begin
                            num_bad = 1'b1;
                        end
                        else
                        begin
                            num_val   = rcp_pkg::cnt_t'(num_val * 10 + digit);
                            num_digit = 1'b1;
                        end
                    end
                    else
                    begin
                        num_bad = 1'b1;
                    end
                end
                return 1'b0;
            end
            PM_DOLLAR:
            begin
                if (b == rcp_pkg::CH_DOLLAR)
                begin
                    clear_number();
                    pmode = PM_LEN;
                    return 1'b0;
                end
                pmode = PM_IDLE;
                res = make_result(rcp_pkg::EV_ERROR, 8'h00, '0, '0);
                return 1'b1;
            end
            PM_PAYLOAD:
            begin
                payload_left = payload_left - rcp_pkg::cnt_t'(1);
                if (payload_left == '0)
                begin
                    pmode   = PM_TERM;
                    cr_seen = 1'b0;
                    term_ok = 1'b0;
                end
                res = make_result(rcp_pkg::EV_BYTE, b, rcp_pkg::idx_t'(arg_no), '0);
                return 1'b1;
            end
            PM_TERM:
            begin
                if (!cr_seen)
                begin
                    term_ok = (b == rcp_pkg::CH_CR);
                    cr_seen = 1'b1;
                    return 1'b0;
                end
                cr_seen = 1'b0;
                if (!(term_ok && b == rcp_pkg::CH_LF))
                begin
                    pmode = PM_IDLE;
                    res = make_result(rcp_pkg::EV_ERROR, 8'h00, '0, '0);
                    return 1'b1;
                end
                args_left = args_left - rcp_pkg::cnt_t'(1);
                if (args_left == '0)
                begin
                    pmode = PM_IDLE;
                    res = make_result(rcp_pkg::EV_ARG_CMD_END, 8'h00, rcp_pkg::idx_t'(arg_no),
                                      rcp_pkg::idx_t'(arg_no + rcp_pkg::cnt_t'(1)));
                    return 1'b1;
                end
                pmode  = PM_DOLLAR;
                arg_no = arg_no + rcp_pkg::cnt_t'(1);
                res = make_result(rcp_pkg::EV_ARG_END, 8'h00,
                                  rcp_pkg::idx_t'(arg_no - rcp_pkg::cnt_t'(1)), '0);
                return 1'b1;
            end
            PM_INLINE:
            begin
                return inline_step(b, res);
            end
            default:
            begin
                pmode = PM_IDLE;
                return 1'b0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    function automatic void put_byte(input logic [7:0] b);
        stream_q.insert(stream_q.size(), b);
    endfunction

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    task automatic push_crlf();
        put_byte(rcp_pkg::CH_CR);
        put_byte(rcp_pkg::CH_LF);
    endtask

    task automatic push_line(input string s);
        push_text(s);
        push_crlf();
    endtask

    function automatic logic [7:0] token_char();
        logic [7:0] c;
        if ($urandom_range(0, 9) != 0)
            return 8'($urandom_range(8'h21, 8'h7E));
        c = 8'($urandom_range(0, 255));
        while (is_blank(c))
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    task automatic push_blanks();
        int n;
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 7))
                0:       put_byte(rcp_pkg::CH_TAB);
                1:       put_byte(CH_VT);
                2:       put_byte(CH_FF);
                3:       put_byte(rcp_pkg::CH_CR);
                4:       put_byte(rcp_pkg::CH_LF);
                default: put_byte(rcp_pkg::CH_SPACE);
            endcase
        end
    endtask

    task automatic push_inline_cmd();
        int         ntok;
        int         tlen;
        logic [7:0] c;
        ntok = $urandom_range(0, 4);
        // open the line with a space or a printable token byte other than a star
        if (ntok == 0 || $urandom_range(0, 3) == 0)
        begin
            put_byte(rcp_pkg::CH_SPACE);
        end
        else
        begin
            c = 8'($urandom_range(8'h21, 8'h7E));
            while (c == rcp_pkg::CH_STAR)
                c = 8'($urandom_range(8'h21, 8'h7E));
            put_byte(c);
        end
        for (int t = 0; t < ntok; t++)
        begin
            if (t != 0)
                push_blanks();
            tlen = $urandom_range(1, 6);
            for (int i = 0; i < tlen; i++)
                put_byte(token_char());
        end
        if ($urandom_range(0, 2) == 0)
            push_blanks();
        push_crlf();
    endtask

    function automatic logic [7:0] header_junk();
        case ($urandom_range(0, 3))
            0:       return rcp_pkg::CH_MINUS;
            1:       return rcp_pkg::CH_CR;
            2:       return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(rcp_pkg::CH_ZERO, rcp_pkg::CH_NINE));
        endcase
    endfunction

    task automatic push_array_cmd(input int flaw);
        int nargs;
        int len;
        int bad_arg;
        int junk_len;
        nargs   = $urandom_range(1, 4);
        bad_arg = $urandom_range(0, nargs - 1);
        push_line($sformatf("*%0d", nargs));
        for (int a = 0; a < nargs; a++)
        begin
            len = $urandom_range(0, 8);
            if (flaw == FLAW_DOLLAR && a == bad_arg)
            begin
                put_byte(rcp_pkg::CH_DOLLAR + 8'($urandom_range(1, 255)));
                return;
            end
            if (flaw == FLAW_HEADER && a == bad_arg)
            begin
                put_byte(rcp_pkg::CH_DOLLAR);
                junk_len = $urandom_range(1, 3);
                for (int i = 0; i < junk_len; i++)
                    put_byte(header_junk());
                push_crlf();
                return;
            end
            push_line($sformatf("$%0d", len));
            for (int i = 0; i < len; i++)
                put_byte(8'($urandom_range(0, 255)));
            if (flaw == FLAW_TERM && a == bad_arg)
            begin
                put_byte(8'($urandom_range(0, 255)));
                put_byte(8'($urandom_range(0, 255)));
                return;
            end
            push_crlf();
        end
    endtask

    task automatic push_broken();
        int n;
        case ($urandom_range(0, 5))
            0:
            begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    put_byte(8'($urandom_range(0, 255)));
                push_crlf();
            end
            1: push_line($sformatf("*%0d", $urandom()));
            2:
            begin
                put_byte(rcp_pkg::CH_STAR);
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    put_byte(header_junk());
                push_crlf();
            end
            3: push_array_cmd(FLAW_HEADER);
            4: push_array_cmd(FLAW_DOLLAR);
            default: push_array_cmd(FLAW_TERM);
        endcase
    endtask

    // ------------------------------------------------------------------
    // Driver: offer queued bytes, predict each accepted item
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            stream_byte <= 8'h00;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (parse_byte(stream_byte, predicted))
                    expected_q.insert(expected_q.size(), predicted);
            end
            // hold a stalled item, otherwise offer the next one or idle
            if (!in_valid || !in_stall)
            begin
                if (stream_q.size() != 0 &&
                    (in_quiet_stretch() || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    in_valid    <= 1'b1;
                    stream_byte <= stream_q.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each accepted result, drive the receiver stall
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = {event_res, data, arg_index, arg_count};
                if (expected_q.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, actual %s",
                             $time, fmt_result(got));
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        $display("%0t: result mismatch, expected %s, actual %s",
                                 $time, fmt_result(want), fmt_result(got));
                    end
                end
            end
            // long hold-off once, random stalls otherwise
            if (cycle_count == HOLD_START)
            begin
                hold_left <= HOLD_LEN;
                out_stall <= 1'b1;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= !in_quiet_stretch() && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // Count cycles and stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("resp_command_parser_top regression: fail");
            $finish;
        end
    end

    initial
    begin
        // directed framing cases: zero counts, a full command, bad headers
        push_line("*0");
        push_line("*-0");
        push_line("*2");
        push_line("$3");
        push_line("GET");
        push_line("$0");
        push_crlf();
        push_line("*-1");
        push_line("*1-");
        push_line("*");
        push_line("*2147483648");
        push_text("*1");
        put_byte(rcp_pkg::CH_CR);
        push_line("x");
        // largest count, then a missing dollar
        push_line("*2147483647");
        push_line("$1");
        push_line("A");
        push_text("X");
        // broken terminators after a payload
        push_line("*1");
        push_line("$1");
        push_text("Zab");
        push_line("*1");
        push_line("$1");
        push_text("Z");
        put_byte(rcp_pkg::CH_CR);
        push_text("b");
        // bytes that cannot start a command
        put_byte(8'h00);
        put_byte(8'h1F);
        put_byte(8'h7F);
        put_byte(8'hFF);
        // inline lines: plain, empty, mixed blanks and high bytes
        push_line("PING");
        push_text(" ");
        put_byte(rcp_pkg::CH_TAB);
        push_crlf();
        push_text("SET k");
        put_byte(rcp_pkg::CH_CR);
        push_text("v");
        put_byte(8'h80);
        put_byte(8'hFF);
        put_byte(8'h01);
        put_byte(CH_VT);
        push_text("w");
        put_byte(CH_FF);
        push_crlf();
        push_line("$x");
        push_line("~");

        // random traffic: mostly well-formed commands, some malformed
        while (stream_q.size() < ITEM_TARGET)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: push_array_cmd(FLAW_NONE);
                11, 12, 13, 14:                   push_inline_cmd();
                default:                          push_broken();
            endcase
        end

        // finish on the largest payload length, left open
        push_line("*1");
        push_line("$2147483647");
        push_text("tail");

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // drain: all items accepted and every result checked
        while (stream_q.size() != 0 || in_valid || expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_count == 0)
            $display("resp_command_parser_top regression: pass");
        else
            $display("resp_command_parser_top regression: fail");
        $finish;
    end

endmodule
